// ===== rtl/mtrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrg_pkg
// Shared constants, codes and controller/datapath interface types of the
// MT19937 generator.
// ----------------------------------------------------------------------------
package mtrg_pkg;

    localparam int STATE_DEPTH  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int MAX_KEY      = 16;

    localparam int IDX_W   = $clog2(STATE_DEPTH + 2);
    localparam int ADDR_W  = $clog2(STATE_DEPTH);
    localparam int KCNT_W  = $clog2(MAX_KEY + 1);
    localparam int KIDX_W  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [IDX_W-1:0] NEVER_SEEDED = IDX_W'(STATE_DEPTH + 1);

    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] MIX_MULT_A   = 32'd1664525;
    localparam logic [31:0] MIX_MULT_B   = 32'd1566083941;
    localparam logic [31:0] KEY_SEED     = 32'd19650218;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TWIST_MAT    = 32'h9908b0df;
    localparam logic [31:0] HI_BIT       = 32'h80000000;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    localparam logic [1:0] FUNC_SEED = 2'd0;
    localparam logic [1:0] FUNC_KEY  = 2'd1;

    localparam logic [1:0] ST_DRAWN       = 2'd0;
    localparam logic [1:0] ST_SEEDED      = 2'd1;
    localparam logic [1:0] ST_KEY_STORED  = 2'd2;
    localparam logic [1:0] ST_KEY_DROPPED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'd1;

    typedef enum logic [1:0] {
        SEED_INPUT,
        SEED_DEFAULT,
        SEED_KEY
    } seed_sel_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_SEED_INIT,
        OP_SEED_MUL,
        OP_SEED_WR,
        OP_MIX_INIT,
        OP_MIX_RD,
        OP_MIX_WR,
        OP_FIX0,
        OP_TW_INIT,
        OP_TW_A,
        OP_TW_B,
        OP_TW_C,
        OP_TW_D,
        OP_DRAW_RD,
        OP_DRAW_TEMP,
        OP_DIV,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t    op;
        seed_sel_t seed_sel;
        logic      load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic idx_never;
        logic idx_empty;
        logic seed_last;
        logic mix_done;
        logic tw_last;
        logic div_last;
    } dp_stat_t;

endpackage

// ===== rtl/mtrg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrg_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mtrg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrg_dp
// Datapath: state memory, key store, seeding and twist arithmetic,
// tempering, bit-serial remainder and result registers.
// ----------------------------------------------------------------------------
module mtrg_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mtrg_pkg::dp_cmd_t              cmd,
    output mtrg_pkg::dp_stat_t             stat,
    input  logic [1:0]                     s_func,
    input  logic [31:0]                    s_seed_word,
    input  logic                           s_key_last,
    input  logic                           cfg_we,
    input  logic [mtrg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output logic [31:0]                    m_raw_word,
    output logic [31:0]                    m_ranged_value,
    output logic [1:0]                     m_status
);

    localparam int IDX_W  = mtrg_pkg::IDX_W;
    localparam int ADDR_W = mtrg_pkg::ADDR_W;
    localparam int KCNT_W = mtrg_pkg::KCNT_W;
    localparam int KIDX_W = mtrg_pkg::KIDX_W;
    localparam logic [IDX_W-1:0] DEPTH_I  = IDX_W'(mtrg_pkg::STATE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_I   = IDX_W'(mtrg_pkg::STATE_DEPTH - 1);
    localparam logic [IDX_W-1:0] LAST2_I  = IDX_W'(mtrg_pkg::STATE_DEPTH - 2);
    localparam logic [IDX_W-1:0] OFFSET_I = IDX_W'(mtrg_pkg::TWIST_OFFSET);
    localparam logic [IDX_W-1:0] ONE_I    = IDX_W'(1);
    localparam logic [KCNT_W-1:0] MAXK    = KCNT_W'(mtrg_pkg::MAX_KEY);

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & mtrg_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtrg_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    logic [31:0]       range_low_reg, range_high_reg;
    logic [IDX_W-1:0]  idx_reg, n_reg, m_reg, i_reg;
    logic [KCNT_W-1:0] key_count_reg, key_len_reg, j_reg;
    logic [31:0]       key_mem [mtrg_pkg::MAX_KEY];
    logic              phase_reg;
    logic [31:0]       p_reg, prod_reg, cur_reg, y_reg, word_reg;
    logic [31:0]       raw_reg, ranged_reg, rem_reg;
    logic [1:0]        status_reg;
    logic [4:0]        div_cnt_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;

    logic [31:0]       seed_val, fold, mix_val, tw_val, span;
    logic [32:0]       div_t;
    logic [IDX_W-1:0]  n_wrap, m_wrap;
    logic [KCNT_W-1:0] kcnt_inc;

    mtrg_ram #(
        .WIDTH(32),
        .DEPTH(mtrg_pkg::STATE_DEPTH)
    ) u_state (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        unique case (cmd.seed_sel)
            mtrg_pkg::SEED_INPUT:   seed_val = word_reg;
            mtrg_pkg::SEED_DEFAULT: seed_val = mtrg_pkg::DEFAULT_SEED;
            mtrg_pkg::SEED_KEY:     seed_val = mtrg_pkg::KEY_SEED;
            default:                seed_val = mtrg_pkg::DEFAULT_SEED;
        endcase
    end

    assign fold   = p_reg ^ (p_reg >> 30);
    assign n_wrap = (n_reg == LAST_I) ? '0 : n_reg + ONE_I;
    assign m_wrap = (m_reg == LAST_I) ? '0 : m_reg + ONE_I;
    assign span   = range_high_reg - range_low_reg + 32'd1;
    assign div_t  = {rem_reg, raw_reg[div_cnt_reg]};
    assign kcnt_inc = (key_count_reg < MAXK) ? key_count_reg + KCNT_W'(1) : key_count_reg;

    assign mix_val = phase_reg
        ? (ram_rdata ^ prod_reg) - {{(32-IDX_W){1'b0}}, i_reg}
        : (ram_rdata ^ prod_reg) + key_mem[j_reg[KIDX_W-1:0]]
          + {{(32-KCNT_W){1'b0}}, j_reg};
    assign tw_val = ram_rdata ^ (y_reg >> 1) ^ (y_reg[0] ? mtrg_pkg::TWIST_MAT : 32'd0);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = seed_val;
        ram_raddr = '0;
        unique case (cmd.op)
            mtrg_pkg::OP_SEED_INIT: begin
                ram_we = 1'b1;
            end
            mtrg_pkg::OP_SEED_WR: begin
                ram_we    = 1'b1;
                ram_waddr = n_reg[ADDR_W-1:0];
                ram_wdata = prod_reg + {{(32-IDX_W){1'b0}}, n_reg};
            end
            mtrg_pkg::OP_MIX_RD:  ram_raddr = i_reg[ADDR_W-1:0];
            mtrg_pkg::OP_MIX_WR: begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[ADDR_W-1:0];
                ram_wdata = mix_val;
            end
            mtrg_pkg::OP_FIX0: begin
                ram_we    = 1'b1;
                ram_wdata = mtrg_pkg::HI_BIT;
            end
            mtrg_pkg::OP_TW_A:    ram_raddr = n_reg[ADDR_W-1:0];
            mtrg_pkg::OP_TW_B:    ram_raddr = n_wrap[ADDR_W-1:0];
            mtrg_pkg::OP_TW_C:    ram_raddr = m_reg[ADDR_W-1:0];
            mtrg_pkg::OP_TW_D: begin
                ram_we    = 1'b1;
                ram_waddr = n_reg[ADDR_W-1:0];
                ram_wdata = tw_val;
            end
            mtrg_pkg::OP_DRAW_RD: ram_raddr = idx_reg[ADDR_W-1:0];
            default: ;
        endcase
    end

    always_comb begin
        stat.idx_never = (idx_reg == mtrg_pkg::NEVER_SEEDED);
        stat.idx_empty = (idx_reg >= DEPTH_I);
        stat.seed_last = (n_reg == LAST_I);
        stat.mix_done  = phase_reg && (n_reg == LAST2_I);
        stat.tw_last   = (n_reg == LAST_I);
        stat.div_last  = (div_cnt_reg == '0);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= 32'd1;
            range_high_reg <= 32'd7;
            idx_reg        <= mtrg_pkg::NEVER_SEEDED;
            key_count_reg  <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    mtrg_pkg::CFG_RANGE_LOW:  range_low_reg  <= cfg_data;
                    mtrg_pkg::CFG_RANGE_HIGH: range_high_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (cmd.op)
                mtrg_pkg::OP_LATCH: begin
                    if (s_func == mtrg_pkg::FUNC_KEY) begin
                        key_count_reg <= s_key_last ? '0 : kcnt_inc;
                    end
                end
                mtrg_pkg::OP_SEED_WR: if (n_reg == LAST_I) idx_reg <= DEPTH_I;
                mtrg_pkg::OP_FIX0:    idx_reg <= DEPTH_I;
                mtrg_pkg::OP_TW_D:    if (n_reg == LAST_I) idx_reg <= '0;
                mtrg_pkg::OP_DRAW_TEMP: idx_reg <= idx_reg + ONE_I;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            mtrg_pkg::OP_LATCH: begin
                word_reg   <= s_seed_word;
                raw_reg    <= '0;
                ranged_reg <= '0;
                if (s_func == mtrg_pkg::FUNC_SEED) begin
                    status_reg <= mtrg_pkg::ST_SEEDED;
                end else if (s_func == mtrg_pkg::FUNC_KEY) begin
                    if (key_count_reg < MAXK) begin
                        key_mem[key_count_reg[KIDX_W-1:0]] <= s_seed_word;
                        status_reg <= s_key_last ? mtrg_pkg::ST_SEEDED
                                                 : mtrg_pkg::ST_KEY_STORED;
                    end else begin
                        status_reg <= mtrg_pkg::ST_KEY_DROPPED;
                    end
                    key_len_reg <= kcnt_inc;
                end else begin
                    status_reg <= mtrg_pkg::ST_DRAWN;
                end
            end
            mtrg_pkg::OP_SEED_INIT: begin
                p_reg <= seed_val;
                n_reg <= ONE_I;
            end
            mtrg_pkg::OP_SEED_MUL: prod_reg <= 32'(mtrg_pkg::SEED_MULT * fold);
            mtrg_pkg::OP_SEED_WR: begin
                p_reg <= prod_reg + {{(32-IDX_W){1'b0}}, n_reg};
                n_reg <= n_reg + ONE_I;
            end
            mtrg_pkg::OP_MIX_INIT: begin
                // the mix starts from word 0 of the fresh seeding
                p_reg     <= seed_val;
                i_reg     <= ONE_I;
                j_reg     <= '0;
                n_reg     <= '0;
                phase_reg <= 1'b0;
            end
            mtrg_pkg::OP_MIX_RD: begin
                prod_reg <= phase_reg ? 32'(mtrg_pkg::MIX_MULT_B * fold)
                                      : 32'(mtrg_pkg::MIX_MULT_A * fold);
            end
            mtrg_pkg::OP_MIX_WR: begin
                p_reg <= mix_val;
                i_reg <= (i_reg + ONE_I >= DEPTH_I) ? ONE_I : i_reg + ONE_I;
                j_reg <= (j_reg + KCNT_W'(1) >= key_len_reg) ? '0 : j_reg + KCNT_W'(1);
                // first pass ends after a full sweep; start the second one
                if (!phase_reg && n_reg == LAST_I) begin
                    phase_reg <= 1'b1;
                    n_reg     <= '0;
                end else begin
                    n_reg <= n_reg + ONE_I;
                end
            end
            mtrg_pkg::OP_TW_INIT: begin
                n_reg <= '0;
                m_reg <= OFFSET_I;
            end
            mtrg_pkg::OP_TW_B: cur_reg <= ram_rdata;
            mtrg_pkg::OP_TW_C: y_reg   <= {cur_reg[31], ram_rdata[30:0]};
            mtrg_pkg::OP_TW_D: begin
                n_reg <= n_reg + ONE_I;
                m_reg <= m_wrap;
            end
            mtrg_pkg::OP_DRAW_TEMP: begin
                raw_reg     <= temper(ram_rdata);
                rem_reg     <= '0;
                div_cnt_reg <= 5'd31;
            end
            mtrg_pkg::OP_DIV: begin
                rem_reg     <= (div_t >= {1'b0, span}) ? 32'(div_t - {1'b0, span})
                                                       : div_t[31:0];
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            mtrg_pkg::OP_FINISH: begin
                ranged_reg <= (span == '0) ? raw_reg : range_low_reg + rem_reg;
            end
            default: ;
        endcase
        if (cmd.load_out) begin
            m_raw_word     <= raw_reg;
            m_ranged_value <= ranged_reg;
            m_status       <= status_reg;
        end
    end

endmodule

// ===== rtl/mtrg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrg_ctrl
// Controller: sequences seeding, key mixing, twist, draw and remainder
// steps, and owns the result handshake.
// ----------------------------------------------------------------------------
module mtrg_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic               s_key_last,
    output logic               m_valid,
    input  logic               m_ready,
    output mtrg_pkg::dp_cmd_t  cmd,
    input  mtrg_pkg::dp_stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE, S_SEED_INIT, S_SEED_MUL, S_SEED_WR,
        S_MIX_INIT, S_MIX_RD, S_MIX_WR, S_FIX0,
        S_TW_INIT, S_TW_A, S_TW_B, S_TW_C, S_TW_D,
        S_DRAW_RD, S_DRAW_TEMP, S_DIV, S_FINISH, S_DONE
    } state_t;

    typedef enum logic [1:0] {RET_DONE, RET_MIX, RET_TWIST} ret_t;

    state_t              state_reg;
    ret_t                ret_reg;
    mtrg_pkg::seed_sel_t seed_sel_reg;
    logic                m_valid_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.op       = mtrg_pkg::OP_NONE;
        cmd.seed_sel = seed_sel_reg;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:      if (s_valid) cmd.op = mtrg_pkg::OP_LATCH;
            S_SEED_INIT: cmd.op = mtrg_pkg::OP_SEED_INIT;
            S_SEED_MUL:  cmd.op = mtrg_pkg::OP_SEED_MUL;
            S_SEED_WR:   cmd.op = mtrg_pkg::OP_SEED_WR;
            S_MIX_INIT:  cmd.op = mtrg_pkg::OP_MIX_INIT;
            S_MIX_RD:    cmd.op = mtrg_pkg::OP_MIX_RD;
            S_MIX_WR:    cmd.op = mtrg_pkg::OP_MIX_WR;
            S_FIX0:      cmd.op = mtrg_pkg::OP_FIX0;
            S_TW_INIT:   cmd.op = mtrg_pkg::OP_TW_INIT;
            S_TW_A:      cmd.op = mtrg_pkg::OP_TW_A;
            S_TW_B:      cmd.op = mtrg_pkg::OP_TW_B;
            S_TW_C:      cmd.op = mtrg_pkg::OP_TW_C;
            S_TW_D:      cmd.op = mtrg_pkg::OP_TW_D;
            S_DRAW_RD:   cmd.op = mtrg_pkg::OP_DRAW_RD;
            S_DRAW_TEMP: cmd.op = mtrg_pkg::OP_DRAW_TEMP;
            S_DIV:       cmd.op = mtrg_pkg::OP_DIV;
            S_FINISH:    cmd.op = mtrg_pkg::OP_FINISH;
            S_DONE:      cmd.load_out = !m_valid_reg || m_ready;
            default:     cmd.op = mtrg_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ret_reg      <= RET_DONE;
            seed_sel_reg <= mtrg_pkg::SEED_INPUT;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        priority if (s_func == mtrg_pkg::FUNC_SEED) begin
                            seed_sel_reg <= mtrg_pkg::SEED_INPUT;
                            ret_reg      <= RET_DONE;
                            state_reg    <= S_SEED_INIT;
                        end else if (s_func == mtrg_pkg::FUNC_KEY) begin
                            if (s_key_last) begin
                                seed_sel_reg <= mtrg_pkg::SEED_KEY;
                                ret_reg      <= RET_MIX;
                                state_reg    <= S_SEED_INIT;
                            end else begin
                                state_reg <= S_DONE;
                            end
                        end else if (stat.idx_never) begin
                            seed_sel_reg <= mtrg_pkg::SEED_DEFAULT;
                            ret_reg      <= RET_TWIST;
                            state_reg    <= S_SEED_INIT;
                        end else if (stat.idx_empty) begin
                            state_reg <= S_TW_INIT;
                        end else begin
                            state_reg <= S_DRAW_RD;
                        end
                    end
                end
                S_SEED_INIT: state_reg <= S_SEED_MUL;
                S_SEED_MUL:  state_reg <= S_SEED_WR;
                S_SEED_WR: begin
                    if (stat.seed_last) begin
                        unique case (ret_reg)
                            RET_DONE:  state_reg <= S_DONE;
                            RET_MIX:   state_reg <= S_MIX_INIT;
                            RET_TWIST: state_reg <= S_TW_INIT;
                            default:   state_reg <= S_DONE;
                        endcase
                    end else begin
                        state_reg <= S_SEED_MUL;
                    end
                end
                S_MIX_INIT: state_reg <= S_MIX_RD;
                S_MIX_RD:   state_reg <= S_MIX_WR;
                S_MIX_WR:   state_reg <= stat.mix_done ? S_FIX0 : S_MIX_RD;
                S_FIX0:     state_reg <= S_DONE;
                S_TW_INIT:  state_reg <= S_TW_A;
                S_TW_A:     state_reg <= S_TW_B;
                S_TW_B:     state_reg <= S_TW_C;
                S_TW_C:     state_reg <= S_TW_D;
                S_TW_D:     state_reg <= stat.tw_last ? S_DRAW_RD : S_TW_A;
                S_DRAW_RD:  state_reg <= S_DRAW_TEMP;
                S_DRAW_TEMP: state_reg <= S_DIV;
                S_DIV:      state_reg <= stat.div_last ? S_FINISH : S_DIV;
                S_FINISH:   state_reg <= S_DONE;
                S_DONE: begin
                    // hand the result over once the output slot is free
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transfer is in progress");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwrites a pending transfer");

    a_valid_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg)
        else $error("loaded result not presented");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.load_out))
        else $error("result valid without a load");
`endif

endmodule

// ===== rtl/mt19937_random_generator.sv =====
`timescale 1ns / 1ps
// Every 624th draw adds a twist of the state, and the first draw after
// reset also a default seeding. One item at a time: the 32-step remainder,
// the seeding steps (multiply, write) and the twist steps (three reads, a
// write) over the state memory keep the input busy until the result is handed over.
// Reset clears control only: index to never seeded, key count 0, range 1..7.
// ----------------------------------------------------------------------------
// mt19937_random_generator
// MT19937 generator with single-word and key seeding, and ranged draws.
// ----------------------------------------------------------------------------
module mt19937_random_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_func,
    input  logic [31:0]                    s_seed_word,
    input  logic                           s_key_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_raw_word,
    output logic [31:0]                    m_ranged_value,
    output logic [1:0]                     m_status,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mtrg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    mtrg_pkg::dp_cmd_t  cmd;
    mtrg_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mtrg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_key_last(s_key_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mtrg_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_func        (s_func),
        .s_seed_word   (s_seed_word),
        .s_key_last    (s_key_last),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_raw_word    (m_raw_word),
        .m_ranged_value(m_ranged_value),
        .m_status      (m_status)
    );

endmodule

// ===== dv/mt19937_random_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_random_checker
// Watches the item, result and register channels of the MT19937 generator,
// predicts each result from its own copy of the generator state and compares
// every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module mt19937_random_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [1:0]                     s_func,
    input  logic [31:0]                    s_seed_word,
    input  logic                           s_key_last,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [31:0]                    m_raw_word,
    input  logic [31:0]                    m_ranged_value,
    input  logic [1:0]                     m_status,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mtrg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             pending,
    output int                             fail_count
);

    localparam int STATE_DEPTH = mtrg_pkg::STATE_DEPTH;

    typedef struct packed {
        logic [31:0] raw;
        logic [31:0] ranged;
        logic [1:0]  status;
    } draw_result_t;

    logic [31:0]  mt_state [0:STATE_DEPTH-1];
    logic [31:0]  key_words [0:mtrg_pkg::MAX_KEY-1];
    int unsigned  mt_pos;
    int unsigned  key_cnt;
    logic [31:0]  rng_low;
    logic [31:0]  rng_high;
    draw_result_t result_q [$];

    assign pending = result_q.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic seed_from_word(input logic [31:0] s);
        logic [31:0] p;
        mt_state[0] = s;
        for (int n = 1; n < STATE_DEPTH; n++) begin
            p = mt_state[n-1];
            mt_state[n] = mtrg_pkg::SEED_MULT * (p ^ (p >> 30)) + 32'(n);
        end
        mt_pos = STATE_DEPTH;
    endtask

    task automatic seed_from_keys(input int unsigned len);
        int i;
        int j;
        int k;
        logic [31:0] p;
        i = 1;
        j = 0;
        seed_from_word(mtrg_pkg::KEY_SEED);
        for (k = (len > STATE_DEPTH) ? len : STATE_DEPTH; k > 0; k--) begin
            p = mt_state[i-1];
            mt_state[i] = (mt_state[i] ^ ((p ^ (p >> 30)) * mtrg_pkg::MIX_MULT_A))
                          + key_words[j] + 32'(j);
            i++;
            j++;
            if (i >= STATE_DEPTH) begin
                mt_state[0] = mt_state[STATE_DEPTH-1];
                i = 1;
            end
            if (j >= len) j = 0;
        end
        for (k = STATE_DEPTH - 1; k > 0; k--) begin
            p = mt_state[i-1];
            mt_state[i] = (mt_state[i] ^ ((p ^ (p >> 30)) * mtrg_pkg::MIX_MULT_B))
                          - 32'(i);
            i++;
            if (i >= STATE_DEPTH) begin
                mt_state[0] = mt_state[STATE_DEPTH-1];
                i = 1;
            end
        end
        mt_state[0] = mtrg_pkg::HI_BIT;
        mt_pos = STATE_DEPTH;
    endtask

    task automatic twist_state();
        logic [31:0] y;
        for (int n = 0; n < STATE_DEPTH; n++) begin
            y = (mt_state[n] & mtrg_pkg::HI_BIT)
                | (mt_state[(n+1) % STATE_DEPTH] & ~mtrg_pkg::HI_BIT);
            mt_state[n] = mt_state[(n + mtrg_pkg::TWIST_OFFSET) % STATE_DEPTH]
                          ^ (y >> 1) ^ (y[0] ? mtrg_pkg::TWIST_MAT : 32'd0);
        end
        mt_pos = 0;
    endtask

    task automatic predict_item(input logic [1:0] func, input logic [31:0] word,
                                input logic last, output draw_result_t r);
        logic [31:0] y;
        logic [31:0] span;
        r = '0;
        if (func == mtrg_pkg::FUNC_SEED) begin
            seed_from_word(word);
            r.status = mtrg_pkg::ST_SEEDED;
        end else if (func == mtrg_pkg::FUNC_KEY) begin
            if (key_cnt < mtrg_pkg::MAX_KEY) begin
                key_words[key_cnt] = word;
                key_cnt++;
                r.status = last ? mtrg_pkg::ST_SEEDED : mtrg_pkg::ST_KEY_STORED;
            end else begin
                r.status = mtrg_pkg::ST_KEY_DROPPED;
            end
            if (last) begin
                seed_from_keys(key_cnt);
                key_cnt = 0;
            end
        end else begin
            if (mt_pos >= STATE_DEPTH) begin
                if (mt_pos == STATE_DEPTH + 1) seed_from_word(mtrg_pkg::DEFAULT_SEED);
                twist_state();
            end
            y = mt_state[mt_pos];
            mt_pos++;
            y ^= (y >> 11);
            y ^= (y << 7) & mtrg_pkg::TEMPER_B;
            y ^= (y << 15) & mtrg_pkg::TEMPER_C;
            y ^= (y >> 18);
            span = rng_high - rng_low + 32'd1;
            r.raw = y;
            r.ranged = (span == 32'd0) ? y : rng_low + y % span;
            r.status = mtrg_pkg::ST_DRAWN;
        end
    endtask

    always @(posedge aclk) begin
        draw_result_t want;
        if (!aresetn) begin
            mt_pos = STATE_DEPTH + 1;
            key_cnt = 0;
            rng_low = 32'd1;
            rng_high = 32'd7;
            fail_count = 0;
            result_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result", m_raw_word, 32'd0);
                end else begin
                    want = result_q.pop_front();
                    if (m_raw_word !== want.raw)
                        report_mismatch("raw_word", m_raw_word, want.raw);
                    if (m_ranged_value !== want.ranged)
                        report_mismatch("ranged_value", m_ranged_value, want.ranged);
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == mtrg_pkg::CFG_RANGE_LOW) rng_low = cfg_data;
                else if (cfg_index == mtrg_pkg::CFG_RANGE_HIGH) rng_high = cfg_data;
            end
            if (s_valid && s_ready) begin
                predict_item(s_func, s_seed_word, s_key_last, want);
                result_q.push_back(want);
            end
        end
    end

endmodule

// ===== dv/tb_mt19937_random_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mt19937_random_generator
// Drives seeds, key words and draws into the generator under several range
// settings with random idling on both channels; a checker predicts results.
// ----------------------------------------------------------------------------
module tb_mt19937_random_generator;

    localparam logic [1:0] FUNC_DRAW     = 2'd2;
    localparam logic [1:0] FUNC_DRAW_ALT = 2'd3;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [1:0]                     s_func;
    logic [31:0]                    s_seed_word;
    logic                           s_key_last;
    logic                           m_valid;
    logic                           m_ready;
    logic [31:0]                    m_raw_word;
    logic [31:0]                    m_ranged_value;
    logic [1:0]                     m_status;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mtrg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                    cfg_data;
    int                             pending;
    int                             fail_count;
    logic                           quiet;
    int                             n_draws;
    int                             n_seeds;
    int                             n_keys;
    int                             n_cfg;

    mt19937_random_generator u_dut (.*);

    mt19937_random_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stall bursts, none once quiet
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] func, input logic [31:0] word,
                             input logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_seed_word <= word;
        s_key_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (func == mtrg_pkg::FUNC_SEED) n_seeds++;
        else if (func == mtrg_pkg::FUNC_KEY) n_keys++;
        else n_draws++;
    endtask

    // hold off until every predicted result has come, then idle out the tail
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_range(input logic [31:0] lo, input logic [31:0] hi);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= mtrg_pkg::CFG_RANGE_LOW;
        cfg_data <= lo;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= mtrg_pkg::CFG_RANGE_HIGH;
        cfg_data <= hi;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        n_cfg += 2;
    endtask

    task automatic random_phase(input int count);
        int sent;
        int r;
        int len;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                send_item(($urandom_range(0, 9) == 0) ? FUNC_DRAW_ALT : FUNC_DRAW,
                          $urandom, 1'($urandom));
                sent++;
            end else if (r < 78) begin
                send_item(mtrg_pkg::FUNC_SEED, $urandom, 1'($urandom));
                sent++;
            end else if (r < 95) begin
                // key sequence, sometimes overrunning the key store
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 19)
                                                  : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    send_item(mtrg_pkg::FUNC_KEY, $urandom, i == len - 1);
                end
                sent += len;
            end else begin
                // stray key word with no last, accumulates into the next key
                send_item(mtrg_pkg::FUNC_KEY, $urandom, 1'b0);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        quiet = 1'b0;
        s_valid = 1'b0;
        s_func = FUNC_DRAW;
        s_seed_word = '0;
        s_key_last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mtrg_pkg::CFG_RANGE_LOW;
        cfg_data = '0;
        n_draws = 0;
        n_seeds = 0;
        n_keys = 0;
        n_cfg = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: draws before any seeding use the default seed
        send_item(FUNC_DRAW, 32'hffff_ffff, 1'b1);
        send_item(FUNC_DRAW_ALT, 32'h0, 1'b0);
        send_item(mtrg_pkg::FUNC_SEED, 32'h0, 1'b0);
        send_item(FUNC_DRAW, 32'h0, 1'b0);
        send_item(mtrg_pkg::FUNC_SEED, 32'hffff_ffff, 1'b1);
        send_item(FUNC_DRAW, 32'h0, 1'b0);
        send_item(mtrg_pkg::FUNC_KEY, 32'hffff_ffff, 1'b1);
        send_item(FUNC_DRAW, 32'h0, 1'b0);
        // overfill the key store; the last word is dropped but still seeds
        for (int i = 0; i < 18; i++) begin
            send_item(mtrg_pkg::FUNC_KEY, (i % 2) ? 32'hffff_ffff : 32'(i), i == 17);
        end
        send_item(FUNC_DRAW, 32'h0, 1'b0);

        write_range(32'h0, 32'hffff_ffff);   // span wraps to zero
        random_phase(100);
        write_range(32'hffff_ffff, 32'h0);   // inverted range
        random_phase(100);
        write_range(32'h0, 32'h0);
        random_phase(100);
        write_range(32'h8000_0000, 32'hffff_fffe);
        random_phase(100);
        write_range($urandom, $urandom);
        random_phase(100);
        write_range(32'd5, 32'd5);
        random_phase(80);
        write_range(32'd1, 32'd7);
        quiet = 1'b1;
        random_phase(80);

        drain();
        repeat (100) @(posedge aclk);
        $display("covered %0d draws, %0d one-word seeds, %0d key words, %0d register writes",
                 n_draws, n_seeds, n_keys, n_cfg);
        $display("ranges included zero span, inverted, single value and reset default");
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mtrg_pkg.sv
rtl/mtrg_ram.sv
rtl/mtrg_dp.sv
rtl/mtrg_ctrl.sv
rtl/mt19937_random_generator.sv
dv/mt19937_random_checker.sv
dv/tb_mt19937_random_generator.sv
